/* hdl/mbcfr_pkg.sv */
// ----------------------------------------------------------------------------
// mbcfr_pkg
// Shared types and constants of the meter-bus command frame recognizer:
// frame store size, frame patterns, item and result layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package mbcfr_pkg;

   // frame store geometry
   localparam int unsigned MAX_FRAME_BYTES = 12;
   localparam int unsigned COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned IDX_W           = $clog2(MAX_FRAME_BYTES);

   // frame lengths
   localparam int unsigned READ_BYTES    = 5;
   localparam int unsigned SET_HDR_BYTES = 6;
   localparam int unsigned SET_BYTES     = 12;

   localparam logic [COUNT_W-1:0] READ_LEN  = COUNT_W'(READ_BYTES);
   localparam logic [COUNT_W-1:0] SET_LEN   = COUNT_W'(SET_BYTES);
   localparam logic [COUNT_W-1:0] FULL_LEN  = COUNT_W'(MAX_FRAME_BYTES);

   // byte positions of the little-endian threshold in a set frame
   localparam int unsigned VALUE_POS = 6;

   // patterns, byte 0 in the lowest lane
   localparam logic [READ_BYTES-1:0][7:0] READ_PATTERN =
      {8'h16, 8'h59, 8'hFE, 8'h5B, 8'h10};
   localparam logic [SET_HDR_BYTES-1:0][7:0] SET_HEADER =
      {8'hFE, 8'h53, 8'h68, 8'h09, 8'h09, 8'h68};

   // input item kinds
   localparam logic MODE_BYTE = 1'b0;
   localparam logic MODE_IDLE = 1'b1;

   // command codes
   localparam logic CMD_READ = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic        command;
      logic [31:0] set_value;
   } result_type;

endpackage

`default_nettype wire

/* hdl/meter_bus_command_frame_recognizer.sv */
// Collects received UART bytes and checks the frame on each line-idle item.
// One item is accepted per cycle while the held item can move on; a recognized
// command passes through the input register, then the result register, to the
// result channel. While a result waiting in the result register is not taken,
// the held item cannot move on and the input stalls.
// The frame store holds twelve bytes; a byte arriving into
// a full store clears it instead. Exactly 10 5B FE 59 16 gives a read command
// (value zero), twelve bytes opening 68 09 09 68 53 FE give a set-threshold
// command with bytes 6..9 as a little-endian value. For a set frame, checksum
// and stop byte are not checked; an unrecognized frame stays in the store.
// ----------------------------------------------------------------------------
// meter_bus_command_frame_recognizer
// Top level: input register, frame store with compare, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_bus_command_frame_recognizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] set_value
   output logic             rsp_tuser    // [0] command
);
   import mbcfr_pkg::*;

   item_type   in_item;
   item_type   item;
   logic       item_valid;
   logic       out_free;
   logic       advance;
   logic       hit;
   result_type result;
   result_type out_data;

   assign in_item.mode    = req_tuser;
   assign in_item.rx_byte = req_tdata;

   // the held item moves on whenever the result register can take a result
   assign advance = item_valid && out_free;

   mbcfr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mbcfr_frame_match u_match (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .hit    (hit),
      .result (result)
   );

   mbcfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && hit),
      .load_data (result),
      .free      (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = out_data.set_value;
   assign rsp_tuser = out_data.command;

endmodule

`default_nettype wire

/* hdl/mbcfr_in_stage.sv */
// ----------------------------------------------------------------------------
// mbcfr_in_stage
// Input register: holds one accepted item until the frame logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mbcfr_in_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire mbcfr_pkg::item_type  in_item,
   input  wire logic                 take,
   output logic                      item_valid,
   output mbcfr_pkg::item_type       item
);
   import mbcfr_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // a slot opens when empty or when the held item moves on this cycle
   assign in_ready = !valid_ff || take;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

/* hdl/mbcfr_frame_match.sv */
// ----------------------------------------------------------------------------
// mbcfr_frame_match
// Frame store and byte count, with the parallel compare against the read
// and set-threshold frames done when the line goes idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mbcfr_frame_match (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire mbcfr_pkg::item_type  item,
   output logic                      hit,
   output mbcfr_pkg::result_type     result
);
   import mbcfr_pkg::*;

   logic [MAX_FRAME_BYTES-1:0][7:0] store_ff;
   logic [COUNT_W-1:0]              count_ff;
   logic [COUNT_W-1:0]              count_in;
   logic                            read_match;
   logic                            set_match;
   logic                            is_idle;

   assign is_idle = (item.mode == MODE_IDLE);

   // pattern compares over the stored bytes
   always_comb begin
      read_match = (count_ff == READ_LEN);
      for (int i = 0; i < READ_BYTES; i++) begin
         if (store_ff[i] != READ_PATTERN[i]) begin
            read_match = 1'b0;
         end
      end
      set_match = (count_ff == SET_LEN);
      for (int i = 0; i < SET_HDR_BYTES; i++) begin
         if (store_ff[i] != SET_HEADER[i]) begin
            set_match = 1'b0;
         end
      end
   end

   // result: read takes priority, value is zero for read
   always_comb begin
      hit              = is_idle && (read_match || set_match);
      result.command   = read_match ? CMD_READ : CMD_SET;
      result.set_value = read_match ? 32'd0 :
                         {store_ff[VALUE_POS+3], store_ff[VALUE_POS+2],
                          store_ff[VALUE_POS+1], store_ff[VALUE_POS]};
   end

   // count update: a byte into a full store or a recognized frame clears it
   always_comb begin
      count_in = count_ff;
      if (step) begin
         if (!is_idle) begin
            if (count_ff >= FULL_LEN) begin
               count_in = '0;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end else if (read_match || set_match) begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // byte write at the current fill position; bytes past the count are never read
   always_ff @(posedge clock) begin
      if (step && !is_idle && (count_ff < FULL_LEN)) begin
         store_ff[count_ff[IDX_W-1:0]] <= item.rx_byte;
      end
   end

endmodule

`default_nettype wire

/* hdl/mbcfr_out_stage.sv */
// ----------------------------------------------------------------------------
// mbcfr_out_stage
// Result register: holds one command until the result channel takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mbcfr_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire mbcfr_pkg::result_type  load_data,
   output logic                        free,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output mbcfr_pkg::result_type       out_data
);
   import mbcfr_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // free when empty or draining this cycle
   assign free     = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire
